// File: sv/u16u8_pkg.sv
package u16u8_pkg;

    // Width of the per-string counters and of the configuration registers.
    localparam int CNT_W      = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CP_W       = 21;
    localparam int LEN_W      = 3;
    localparam int POS_W      = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARACTERS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_CAPACITY  = CFG_IDX_W'(1);

    // Upper six bits of a surrogate code unit.
    localparam logic [5:0]  SURR_HIGH_TAG  = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG   = 6'b110111;
    localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;
    localparam logic [15:0] CP_MAX_1BYTE   = 16'h007F;
    localparam logic [15:0] CP_MAX_2BYTE   = 16'h07FF;
    localparam logic [CP_W-1:0] SUPP_BASE  = CP_W'(32'h10000);

    localparam logic [7:0] LEAD_2BYTE = 8'hC0;
    localparam logic [7:0] LEAD_3BYTE = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE = 8'hF0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;

    // One queued job: up to two characters and an optional summary.
    // A length of zero means that character slot is empty.
    typedef struct packed {
        logic [CP_W-1:0]  a_cp;
        logic [LEN_W-1:0] a_len;
        logic [15:0]      b_cp;
        logic [LEN_W-1:0] b_len;
        logic             summary;
        logic             complete;
        logic [CNT_W-1:0] units_read;
        logic [CNT_W-1:0] bytes_written;
    } job_t;

    // Queue status seen by the front end.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W + 1 - LEN_W){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Byte number idx of the UTF-8 form of cp, whose length is len.
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0]  cp,
                                             input logic [LEN_W-1:0] len,
                                             input logic [1:0]       idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: begin
                case (idx)
                    2'd0:    b = LEAD_2BYTE | {3'b000, cp[10:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            3'd3: begin
                case (idx)
                    2'd0:    b = LEAD_3BYTE | {4'h0, cp[15:12]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (idx)
                    2'd0:    b = LEAD_4BYTE | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[17:12]};
                    2'd2:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/u16u8_front.sv
module u16u8_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [u16u8_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [u16u8_pkg::CNT_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_code_unit,
    input  logic                        s_end_of_string,
    input  u16u8_pkg::fifo_status_t     q_status,
    output logic                        q_push,
    output u16u8_pkg::job_t             q_job
);
    import u16u8_pkg::*;

    logic [CNT_W-1:0] max_chars_reg;
    logic [CNT_W-1:0] capacity_reg;
    logic [9:0]       held_high_reg, held_high_next;
    logic             held_valid_reg, held_valid_next;
    logic             halted_reg, halted_next;
    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic [CNT_W-1:0] read_count_reg, read_count_next;
    logic [CNT_W-1:0] write_count_reg, write_count_next;

    logic             in_fire;
    logic             is_low, is_high;
    logic [CP_W-1:0]  pair_cp, a_cp;
    logic [LEN_W-1:0] a_len, a_units, b_len;
    logic             a_try, a_lim, a_cap, a_ok, halt_a;
    logic [CNT_W-1:0] cc1, rc1, wc1;
    logic [15:0]      b_cp;
    logic             b_try, b_lim, b_cap, b_ok, halt_b, hold;

    assign s_ready = !q_status.full;
    assign in_fire = s_valid && s_ready;
    assign is_low  = (s_code_unit[15:10] == SURR_LOW_TAG);
    assign is_high = (s_code_unit[15:10] == SURR_HIGH_TAG);

    always_comb begin
        // First slot: the held high surrogate, as a pair or as a replacement.
        pair_cp = SUPP_BASE + CP_W'({held_high_reg, s_code_unit[9:0]});
        a_try   = !halted_reg && held_valid_reg;
        a_cp    = is_low ? pair_cp : CP_W'(REPLACEMENT_CP);
        a_len   = is_low ? LEN_W'(4) : LEN_W'(3);
        a_units = is_low ? LEN_W'(2) : LEN_W'(1);
        a_lim   = (max_chars_reg != '0) && (char_count_reg >= max_chars_reg);
        a_cap   = ({1'b0, write_count_reg} + (CNT_W + 1)'(a_len)) > {1'b0, capacity_reg};
        a_ok    = a_try && !a_lim && !a_cap;
        halt_a  = halted_reg || (a_try && (a_lim || a_cap));
        cc1     = a_ok ? sat_add(char_count_reg, LEN_W'(1)) : char_count_reg;
        rc1     = a_ok ? sat_add(read_count_reg, a_units) : read_count_reg;
        wc1     = a_ok ? sat_add(write_count_reg, a_len) : write_count_reg;

        // Second slot: the new unit on its own.
        b_cp  = (is_low || is_high) ? REPLACEMENT_CP : s_code_unit;
        b_len = (b_cp <= CP_MAX_1BYTE) ? LEN_W'(1) :
                (b_cp <= CP_MAX_2BYTE) ? LEN_W'(2) : LEN_W'(3);
        hold  = !halt_a && !(a_try && is_low) && is_high && !s_end_of_string;
        b_try = !halt_a && !(a_try && is_low) && !(is_high && !s_end_of_string);
        b_lim = (max_chars_reg != '0) && (cc1 >= max_chars_reg);
        b_cap = ({1'b0, wc1} + (CNT_W + 1)'(b_len)) > {1'b0, capacity_reg};
        b_ok  = b_try && !b_lim && !b_cap;
        halt_b = halt_a || (b_try && (b_lim || b_cap));

        q_job.a_cp          = a_cp;
        q_job.a_len         = a_ok ? a_len : '0;
        q_job.b_cp          = b_cp;
        q_job.b_len         = b_ok ? b_len : '0;
        q_job.summary       = s_end_of_string;
        q_job.complete      = !halt_b;
        q_job.units_read    = b_ok ? sat_add(rc1, LEN_W'(1)) : rc1;
        q_job.bytes_written = b_ok ? sat_add(wc1, b_len) : wc1;
        q_push = in_fire && (a_ok || b_ok || s_end_of_string);

        held_high_reg_hold: begin
            held_high_next = hold ? s_code_unit[9:0] : held_high_reg;
        end
        if (s_end_of_string) begin
            held_valid_next  = 1'b0;
            halted_next      = 1'b0;
            char_count_next  = '0;
            read_count_next  = '0;
            write_count_next = '0;
            held_high_next   = '0;
        end else begin
            held_valid_next  = hold;
            halted_next      = halt_b;
            char_count_next  = b_ok ? sat_add(cc1, LEN_W'(1)) : cc1;
            read_count_next  = q_job.units_read;
            write_count_next = q_job.bytes_written;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg   <= '0;
            capacity_reg    <= '1;
            held_high_reg   <= '0;
            held_valid_reg  <= 1'b0;
            halted_reg      <= 1'b0;
            char_count_reg  <= '0;
            read_count_reg  <= '0;
            write_count_reg <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_MAX_CHARACTERS) begin
                    max_chars_reg <= cfg_data;
                end else if (cfg_index == REG_BYTE_CAPACITY) begin
                    capacity_reg <= cfg_data;
                end
            end
            if (in_fire) begin
                held_high_reg   <= held_high_next;
                held_valid_reg  <= held_valid_next;
                halted_reg      <= halted_next;
                char_count_reg  <= char_count_next;
                read_count_reg  <= read_count_next;
                write_count_reg <= write_count_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_hold_when_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        !(held_valid_reg && halted_reg))
        else $error("front: surrogate held while string is halted");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_end_of_string |=>
            read_count_reg == '0 && write_count_reg == '0 && !held_valid_reg)
        else $error("front: per-string state not cleared after end of string");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("front: job pushed into a full queue");
`endif

endmodule

// File: sv/u16u8_fifo.sv
module u16u8_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  u16u8_pkg::job_t         push_job,
    input  logic                    pop,
    output u16u8_pkg::job_t         head_job,
    output u16u8_pkg::fifo_status_t status
);
    import u16u8_pkg::*;

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign status.full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_AW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("fifo: occupancy above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("fifo: pop from empty queue");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0])
        else $error("fifo: pointers disagree with occupancy");
`endif

endmodule

// File: sv/u16u8_back.sv
module u16u8_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  u16u8_pkg::job_t             head_job,
    input  u16u8_pkg::fifo_status_t     q_status,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_is_summary,
    output logic                        m_run_last,
    output logic                        m_complete,
    output logic [u16u8_pkg::CNT_W-1:0] m_units_read,
    output logic [u16u8_pkg::CNT_W-1:0] m_bytes_written
);
    import u16u8_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       byte_reg;
    logic             summary_reg, last_reg, complete_reg;
    logic [CNT_W-1:0] units_reg, bytes_reg;

    logic             load, last;
    logic [POS_W:0]   total;
    logic [POS_W-1:0] b_idx;
    logic             in_a, in_b;
    logic [7:0]       byte_val;

    always_comb begin
        load  = !q_status.empty && (!m_valid_reg || m_ready);
        total = (POS_W + 1)'(head_job.a_len) + (POS_W + 1)'(head_job.b_len)
              + (POS_W + 1)'(head_job.summary);
        last  = ({1'b0, pos_reg} == total - (POS_W + 1)'(1));
        in_a  = pos_reg < POS_W'(head_job.a_len);
        in_b  = !in_a && (pos_reg < POS_W'(head_job.a_len) + POS_W'(head_job.b_len));
        b_idx = pos_reg - POS_W'(head_job.a_len);
        if (in_a) begin
            byte_val = utf8_byte(head_job.a_cp, head_job.a_len, pos_reg[1:0]);
        end else if (in_b) begin
            byte_val = utf8_byte(CP_W'(head_job.b_cp), head_job.b_len, b_idx[1:0]);
        end else begin
            byte_val = 8'h00;
        end
        q_pop        = load && last;
        pos_next     = load ? (last ? '0 : pos_reg + POS_W'(1)) : pos_reg;
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg     <= byte_val;
            summary_reg  <= !in_a && !in_b;
            last_reg     <= last;
            complete_reg <= !in_a && !in_b && head_job.complete;
            units_reg    <= (!in_a && !in_b) ? head_job.units_read : '0;
            bytes_reg    <= (!in_a && !in_b) ? head_job.bytes_written : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_is_summary    = summary_reg;
    assign m_run_last      = last_reg;
    assign m_complete      = complete_reg;
    assign m_units_read    = units_reg;
    assign m_bytes_written = bytes_reg;

`ifndef SYNTHESIS
    a_pos_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != '0 |-> !q_status.empty)
        else $error("back: byte position set with no job at the head");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_status.empty |-> {1'b0, pos_reg} < total)
        else $error("back: byte position past the end of the job");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && summary_reg |-> last_reg)
        else $error("back: summary is not the last result of its item");
`endif

endmodule

// File: sv/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Code units enter one item at a time on the s_
// channel, with s_end_of_string on the last unit of a string; UTF-8 bytes
// leave one item per cycle on the m_ channel while m_ready is high, and the
// end-of-string unit is followed by one summary item (m_is_summary = 1)
// carrying m_complete, m_units_read and m_bytes_written, after which the
// per-string counters clear. m_run_last marks the last item caused by each
// input unit. Surrogate pairs become 4-byte sequences and lone surrogates
// become EF BF BD. A string stops converting, without a partial character,
// once max_characters (index 0, zero means no limit) characters are out or
// the next character would not fit in byte_capacity (index 1, reset
// 0xFFFFFF); write the registers only while the block is idle. The front end
// classifies each unit and does all string accounting in the cycle it is
// accepted, then pushes a job into a four-entry queue; the back end serializes
// jobs into bytes, one per cycle while m_ready is high, with no gap between
// jobs. A unit causes one to three items for a basic-plane character, four
// for a pair, up to seven when a broken pair, a new character and a summary
// all fall on one unit. Input is taken every cycle while the queue has room.
module utf16_to_utf8_transcoder (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [u16u8_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [u16u8_pkg::CNT_W-1:0] cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_code_unit,
    input  logic                        s_end_of_string,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_is_summary,
    output logic                        m_run_last,
    output logic                        m_complete,
    output logic [u16u8_pkg::CNT_W-1:0] m_units_read,
    output logic [u16u8_pkg::CNT_W-1:0] m_bytes_written
);
    import u16u8_pkg::*;

    // Configuration writes are always accepted; cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    fifo_status_t q_status;
    job_t         push_job;
    job_t         head_job;
    logic         q_push;
    logic         q_pop;

    // Front end: classification, surrogate holding and string accounting.
    u16u8_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_unit     (s_code_unit),
        .s_end_of_string (s_end_of_string),
        .q_status        (q_status),
        .q_push          (q_push),
        .q_job           (push_job)
    );

    // Job queue that lets the two halves stall independently.
    u16u8_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back end: byte serializer with a registered output stage.
    u16u8_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_job        (head_job),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_summary    (m_is_summary),
        .m_run_last      (m_run_last),
        .m_complete      (m_complete),
        .m_units_read    (m_units_read),
        .m_bytes_written (m_bytes_written)
    );

endmodule

// File: sim/utf16_to_utf8_transcoder_test.sv
module utf16_to_utf8_transcoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int TIMEOUT_NS  = 2_000_000;
    // Cycles allowed after the last predicted item before registers change or
    // the run ends. Units that cause no item still pass through the front end.
    localparam int SETTLE_CYCLES = 16;
    // A register index past the end of the map; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = CFG_IDX_W'(2);
    localparam logic [CNT_W-1:0] CNT_ALL_ONES = {CNT_W{1'b1}};

    // One item on the result channel, as the predictor expects it.
    typedef struct {
        logic [7:0]       out_byte;
        logic             is_summary;
        logic             run_last;
        logic             complete;
        logic [CNT_W-1:0] units_read;
        logic [CNT_W-1:0] bytes_written;
    } utf8_item_t;

    // Tracks the per-string transcoder state, predicts the UTF-8 bytes and
    // summaries that each accepted code unit causes, and checks them in order.
    class utf8_tracker;
        logic [CNT_W-1:0] max_chars;
        logic [CNT_W-1:0] byte_cap;
        logic [9:0]       held_bits;
        bit               held;
        bit               stopped;
        logic [CNT_W-1:0] chars_done;
        logic [CNT_W-1:0] units_done;
        logic [CNT_W-1:0] bytes_done;
        utf8_item_t       expected_utf8[$];
        int unsigned      mismatches;
        int unsigned      units_taken;
        int unsigned      bytes_seen;
        int unsigned      summaries_seen;

        function new();
            max_chars      = '0;
            byte_cap       = CNT_ALL_ONES;
            mismatches     = 0;
            units_taken    = 0;
            bytes_seen     = 0;
            summaries_seen = 0;
            clear_string();
        endfunction

        function void clear_string();
            held_bits  = '0;
            held       = 1'b0;
            stopped    = 1'b0;
            chars_done = '0;
            units_done = '0;
            bytes_done = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
            case (idx)
                REG_MAX_CHARACTERS: max_chars = data;
                REG_BYTE_CAPACITY:  byte_cap = data;
                default: ;
            endcase
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] a, int unsigned b);
            logic [CNT_W:0] s;
            s = {1'b0, a} + (CNT_W + 1)'(b);
            return s[CNT_W] ? CNT_ALL_ONES : s[CNT_W-1:0];
        endfunction

        function void push_byte(logic [7:0] b);
            utf8_item_t it;
            it.out_byte      = b;
            it.is_summary    = 1'b0;
            it.run_last      = 1'b0;
            it.complete      = 1'b0;
            it.units_read    = '0;
            it.bytes_written = '0;
            expected_utf8.insert(expected_utf8.size(), it);
        endfunction

        // Encodes one code point that consumes the given number of units, or
        // halts the string when the character limit or byte capacity is hit.
        function void encode_char(logic [20:0] cp, int unsigned units);
            int unsigned len;
            if (stopped)
                return;
            if (max_chars != 0 && chars_done >= max_chars) begin
                stopped = 1'b1;
                return;
            end
            len = cp <= 21'h7F ? 1 : cp <= 21'h7FF ? 2 : cp <= 21'hFFFF ? 3 : 4;
            if (32'(bytes_done) + len > 32'(byte_cap)) begin
                stopped = 1'b1;
                return;
            end
            case (len)
                1: push_byte({1'b0, cp[6:0]});
                2: begin
                    push_byte(8'hC0 | {3'b000, cp[10:6]});
                    push_byte(8'h80 | {2'b00, cp[5:0]});
                end
                3: begin
                    push_byte(8'hE0 | {4'h0, cp[15:12]});
                    push_byte(8'h80 | {2'b00, cp[11:6]});
                    push_byte(8'h80 | {2'b00, cp[5:0]});
                end
                default: begin
                    push_byte(8'hF0 | {5'b00000, cp[20:18]});
                    push_byte(8'h80 | {2'b00, cp[17:12]});
                    push_byte(8'h80 | {2'b00, cp[11:6]});
                    push_byte(8'h80 | {2'b00, cp[5:0]});
                end
            endcase
            bytes_done = bump(bytes_done, len);
            units_done = bump(units_done, units);
            chars_done = bump(chars_done, 1);
        endfunction

        function void take_unit(logic [15:0] cu, logic eos);
            bit         is_low;
            bit         is_high;
            bit         unit_done;
            int         start;
            utf8_item_t summary;
            is_low  = cu[15:10] == SURR_LOW_TAG;
            is_high = cu[15:10] == SURR_HIGH_TAG;
            start   = expected_utf8.size();
            units_taken++;
            if (!stopped) begin
                unit_done = 1'b0;
                if (held) begin
                    held = 1'b0;
                    if (is_low) begin
                        encode_char(21'h10000 + {held_bits, cu[9:0]}, 2);
                        unit_done = 1'b1;
                    end else begin
                        encode_char(21'(REPLACEMENT_CP), 1);
                    end
                end
                if (!unit_done && !stopped) begin
                    if (is_high && !eos) begin
                        held_bits = cu[9:0];
                        held      = 1'b1;
                    end else if (is_high || is_low) begin
                        encode_char(21'(REPLACEMENT_CP), 1);
                    end else begin
                        encode_char(21'(cu), 1);
                    end
                end
            end
            if (eos) begin
                summary.out_byte      = 8'h00;
                summary.is_summary    = 1'b1;
                summary.run_last      = 1'b0;
                summary.complete      = !stopped;
                summary.units_read    = units_done;
                summary.bytes_written = bytes_done;
                expected_utf8.insert(expected_utf8.size(), summary);
                clear_string();
            end
            if (expected_utf8.size() > start)
                expected_utf8[expected_utf8.size() - 1].run_last = 1'b1;
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            end
        endfunction

        function void match_output(utf8_item_t got);
            utf8_item_t want;
            if (got.is_summary)
                summaries_seen++;
            else
                bytes_seen++;
            if (expected_utf8.size() == 0) begin
                mismatches++;
                $display("%0t: item with none expected, actual byte %h summary %b",
                         $time, got.out_byte, got.is_summary);
                return;
            end
            want = expected_utf8.pop_front();
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("is_summary", 32'(want.is_summary), 32'(got.is_summary));
            compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
            compare_field("complete", 32'(want.complete), 32'(got.complete));
            compare_field("units_read", 32'(want.units_read), 32'(got.units_read));
            compare_field("bytes_written", 32'(want.bytes_written),
                          32'(got.bytes_written));
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [CNT_W-1:0]     cfg_data        = '0;
    logic                 s_valid         = 1'b0;
    logic [15:0]          s_code_unit     = '0;
    logic                 s_end_of_string = 1'b0;
    logic                 m_ready         = 1'b0;

    logic                 cfg_ready;
    logic                 s_ready;
    logic                 m_valid;
    logic [7:0]           m_out_byte;
    logic                 m_is_summary;
    logic                 m_run_last;
    logic                 m_complete;
    logic [CNT_W-1:0]     m_units_read;
    logic [CNT_W-1:0]     m_bytes_written;

    // Idle rates in percent for the sender and the receiver, and the length of
    // a forced receiver hold-off still to run, in cycles.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left     = 0;

    utf8_tracker tracker = new();

    utf16_to_utf8_transcoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_unit     (s_code_unit),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_summary    (m_is_summary),
        .m_run_last      (m_run_last),
        .m_complete      (m_complete),
        .m_units_read    (m_units_read),
        .m_bytes_written (m_bytes_written)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // The receiver decides its ready at each falling edge. A pending hold-off
    // keeps it low for a long stretch so that the internal job queue fills up
    // and the block has to stall its input.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every item taken on the result channel is checked against the oldest
    // prediction. Outputs are sampled at the rising edge, before they update.
    always @(posedge aclk) begin
        utf8_item_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.out_byte      = m_out_byte;
            seen.is_summary    = m_is_summary;
            seen.run_last      = m_run_last;
            seen.complete      = m_complete;
            seen.units_read    = m_units_read;
            seen.bytes_written = m_bytes_written;
            tracker.match_output(seen);
        end
    end

    // Writes one configuration register. Only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offers one code unit. Valid stays high from one item to the next unless
    // the sender decides to idle first, so back-to-back items are possible.
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_code_unit     <= cu;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
        tracker.take_unit(cu, eos);
    endtask

    // Sends a whole string; the flag goes on its last unit.
    task automatic send_string(input logic [15:0] units[$]);
        foreach (units[i])
            send_unit(units[i], i == units.size() - 1);
    endtask

    // Builds a short string that is mostly well formed: ASCII, two- and
    // three-byte characters and surrogate pairs, with some lone surrogates
    // and raw random units mixed in.
    task automatic send_random_string(input int max_len);
        logic [15:0] units[$];
        logic [15:0] u;
        logic [9:0]  hi;
        logic [9:0]  lo;
        int          n;
        int          pick;
        n = $urandom_range(1, max_len);
        while (units.size() < n) begin
            pick = $urandom_range(99);
            hi   = 10'($urandom);
            lo   = 10'($urandom);
            if (pick < 30) begin
                units.insert(units.size(), 16'($urandom_range(0, 16'h7F)));
            end else if (pick < 45) begin
                units.insert(units.size(), 16'($urandom_range(16'h80, 16'h7FF)));
            end else if (pick < 65) begin
                u = 16'($urandom_range(16'h800, 16'hFFFF));
                // Move a surrogate draw out of the surrogate block.
                if (u[15:11] == SURR_HIGH_TAG[5:1])
                    u = u ^ 16'h4000;
                units.insert(units.size(), u);
            end else if (pick < 85) begin
                units.insert(units.size(), {SURR_HIGH_TAG, hi});
                units.insert(units.size(), {SURR_LOW_TAG, lo});
            end else if (pick < 90) begin
                units.insert(units.size(), {SURR_HIGH_TAG, hi});
            end else if (pick < 95) begin
                units.insert(units.size(), {SURR_LOW_TAG, lo});
            end else begin
                units.insert(units.size(), 16'($urandom));
            end
        end
        send_string(units);
    endtask

    // Stops offering items, waits until every predicted item has come out and
    // then waits SETTLE_CYCLES more for units that caused no item.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.expected_utf8.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] text[$];

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 73;

        // Directed strings under the reset configuration. The first covers
        // the range edges of each UTF-8 length, the smallest and largest
        // surrogate pairs, a lone low surrogate, a held high surrogate that is
        // broken by a plain unit and by another high surrogate, and a high
        // surrogate on the last unit of a string.
        text = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
                 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00,
                 16'hD801, 16'h0041, 16'hD802, 16'hD803, 16'hDC05, 16'hDBFF};
        send_string(text);
        // A broken pair whose second unit is a three-byte character at the end
        // of the string gives the most items one unit can cause.
        text = '{16'hD800, 16'h20AC};
        send_string(text);
        settle();

        // The character limit cuts the string short.
        write_reg(REG_MAX_CHARACTERS, 24'd2);
        text = '{16'h0041, 16'h0042, 16'h0043};
        send_string(text);
        settle();

        // The byte capacity refuses a character that would not fit whole.
        write_reg(REG_MAX_CHARACTERS, '0);
        write_reg(REG_BYTE_CAPACITY, 24'd5);
        text = '{16'h20AC, 16'h20AC};
        send_string(text);
        settle();

        // Random strings with no limit. The receiver first holds off for a
        // long stretch while the sender keeps offering units. A write to an
        // index past the register map must leave the configuration alone.
        write_reg(REG_BYTE_CAPACITY, CNT_ALL_ONES);
        write_reg(UNUSED_REG_INDEX, 24'd3);
        hold_left = 400;
        while (tracker.units_taken < 110)
            send_random_string(8);
        settle();

        // Tight byte capacity with the largest character limit, idle rates
        // swapped.
        send_idle_pct = 73;
        recv_idle_pct = 24;
        write_reg(REG_MAX_CHARACTERS, CNT_ALL_ONES);
        write_reg(REG_BYTE_CAPACITY, 24'($urandom_range(6, 30)));
        while (tracker.units_taken < 190)
            send_random_string(8);
        settle();

        // Small character limit at full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MAX_CHARACTERS, 24'($urandom_range(1, 5)));
        write_reg(REG_BYTE_CAPACITY, CNT_ALL_ONES);
        while (tracker.units_taken < 260)
            send_random_string(8);
        settle();

        // Zero capacity: nothing fits, so only summaries come out.
        write_reg(REG_MAX_CHARACTERS, '0);
        write_reg(REG_BYTE_CAPACITY, '0);
        while (tracker.units_taken < 285)
            send_random_string(6);
        settle();

        $display("Transcoded %0d code units in %0d strings under several limit settings;",
                 tracker.units_taken, tracker.summaries_seen);
        $display("%0d UTF-8 bytes and %0d summaries checked, %0d mismatches.",
                 tracker.bytes_seen, tracker.summaries_seen, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d items still expected.", tracker.expected_utf8.size());
        $display("FAIL");
        $finish;
    end

endmodule
